### rtl/ppa_pkg.sv
// Shared constants, types and opcodes of the polygon containment and area block.
package ppa_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 16;
  localparam int MIN_POLY     = 3;
  localparam int OP_W         = 2;
  localparam int AREA_W       = 48;
  localparam int VCOUNT_W     = 9;

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int EXT_W  = COORD_BITS + 1;
  localparam int PROD_W = 2 * EXT_W;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int SAT_W  = (ACC_W > AREA_W) ? ACC_W : AREA_W;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic shift_in;
    logic rotate;
  } chain_ctrl_t;

  typedef struct packed {
    logic start;
    logic edge_en;
    logic first;
    logic finish;
  } edge_ctrl_t;

endpackage

### rtl/ppa_in_if.sv
// Request channel: opcode and coordinate pair with valid/ready handshake.
interface ppa_in_if import ppa_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              opcode;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, output opcode, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input opcode, input coord_x, input coord_y, output ready);
endinterface

### rtl/ppa_out_if.sv
// Result channel: containment, twice area, vertex count and drop flag.
interface ppa_out_if import ppa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                inside_res;
  logic [AREA_W-1:0]   twice_area;
  logic [VCOUNT_W-1:0] vertex_count;
  logic                dropped;

  modport source (output valid, output inside_res, output twice_area, output vertex_count,
                  output dropped, input ready);
  modport sink   (input valid, input inside_res, input twice_area, input vertex_count,
                  input dropped, output ready);
endinterface

### rtl/ppa_cell.sv
// One vertex cell of the ring: a coordinate pair register that loads its neighbor.
module ppa_cell import ppa_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  vertex_t d,
  output vertex_t q
);

  vertex_t vtx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vtx_r <= d;
    end
  end

  assign q = vtx_r;

endmodule

### rtl/ppa_chain.sv
// Row of vertex cells: appends enter at the tail, a query rotates the whole ring once.
module ppa_chain import ppa_pkg::*; (
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  input  vertex_t     new_vtx,
  output vertex_t     head,
  output vertex_t     tail
);

  vertex_t cell_q [MAX_VERTICES];
  vertex_t tail_in;
  logic    en;

  assign en      = ctrl.shift_in | ctrl.rotate;
  // wrap the head back into the tail while walking
  assign tail_in = ctrl.rotate ? cell_q[0] : new_vtx;

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    if (k == MAX_VERTICES - 1) begin : g_tail
      ppa_cell u_cell (.clk(clk), .en(en), .d(tail_in), .q(cell_q[k]));
    end else begin : g_body
      ppa_cell u_cell (.clk(clk), .en(en), .d(cell_q[k+1]), .q(cell_q[k]));
    end
  end

  assign head = cell_q[0];
  assign tail = cell_q[MAX_VERTICES-1];

endmodule

### rtl/ppa_edge_unit.sv
// Pipelined edge unit: crossing test by cross-multiplication and shoelace accumulation.
module ppa_edge_unit import ppa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  edge_ctrl_t        ctrl,
  input  vertex_t           point,
  input  vertex_t           cur,
  input  vertex_t           prev,
  output logic              in_poly,
  output logic [AREA_W-1:0] area
);

  vertex_t pt_r;
  vertex_t last_r;
  vertex_t prev_sel;

  logic signed [EXT_W-1:0] xi, yi, xj, yj, px, py;

  logic signed [EXT_W-1:0] sumx_r, dy_r, ax_r, bx_r, by_r;
  logic                    s1_vld_r, s1_cross_r, s1_dpos_r;

  logic signed [PROD_W-1:0] area_p_r, lhs_r, rhs_r;
  logic                     s2_vld_r, s2_cross_r, s2_dpos_r;

  logic signed [ACC_W-1:0] acc_r;
  logic                    par_r;
  logic                    flip;

  logic [ACC_W-1:0]  abs_v;
  logic [SAT_W-1:0]  abs_ext;
  logic [AREA_W-1:0] area_r;
  logic              inside_r;

  // the first real vertex pairs with the newest one, captured at query start
  assign prev_sel = ctrl.first ? last_r : prev;

  assign xi = EXT_W'($signed(cur.x));
  assign yi = EXT_W'($signed(cur.y));
  assign xj = EXT_W'($signed(prev_sel.x));
  assign yj = EXT_W'($signed(prev_sel.y));
  assign px = EXT_W'($signed(pt_r.x));
  assign py = EXT_W'($signed(pt_r.y));

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pt_r   <= point;
      last_r <= prev;
    end
  end

  // operand stage
  always_ff @(posedge clk) begin
    sumx_r     <= xj + xi;
    dy_r       <= yj - yi;
    ax_r       <= px - xi;
    bx_r       <= xj - xi;
    by_r       <= py - yi;
    s1_cross_r <= (yi > py) != (yj > py);
    s1_dpos_r  <= yj > yi;
  end

  // product stage
  always_ff @(posedge clk) begin
    area_p_r   <= PROD_W'(sumx_r) * PROD_W'(dy_r);
    lhs_r      <= PROD_W'(ax_r) * PROD_W'(dy_r);
    rhs_r      <= PROD_W'(bx_r) * PROD_W'(by_r);
    s2_cross_r <= s1_cross_r;
    s2_dpos_r  <= s1_dpos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctrl.edge_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  assign flip = s2_cross_r && (s2_dpos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc_r <= '0;
      par_r <= 1'b0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(area_p_r);
      par_r <= par_r ^ flip;
    end
  end

  assign abs_v   = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign abs_ext = SAT_W'(abs_v);

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      inside_r <= par_r;
      area_r   <= (abs_ext > SAT_W'(AREA_MAX)) ? AREA_MAX : AREA_W'(abs_ext);
    end
  end

  assign in_poly = inside_r;
  assign area    = area_r;

endmodule

### rtl/polygon_point_in_and_area_top.sv
// Polygon store with even-odd point containment and twice the shoelace area.
// Vertices live in a ring of MAX_VERTICES cells; clear and append requests are taken while idle,
// and an append to a full ring is dropped and flagged until the next clear. A query rotates the
// ring once around, one cell per cycle, so it walks all MAX_VERTICES cells whatever the vertex
// count, then drains the three-stage edge pipeline; once the output register is free, the result
// is offered and new requests are taken again in the same cycle. The result sits in an output
// register, so the block accepts clear and append requests while it waits there. With fewer than
// three vertices a query reports outside and zero area.
module polygon_point_in_and_area_top import ppa_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ppa_in_if.sink       in_chan,
  ppa_out_if.source    out_chan
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  walk_r, walk_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              dropped_r, dropped_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;
  logic              in_fire;
  logic [CNT_W:0]    span;

  logic                inside_out_r;
  logic [AREA_W-1:0]   area_out_r;
  logic [VCOUNT_W-1:0] vcount_out_r;
  logic                dropped_out_r;

  chain_ctrl_t cctrl;
  edge_ctrl_t  ectrl;
  vertex_t     req_vtx;
  vertex_t     head;
  vertex_t     tail;
  logic        eu_inside;
  logic [AREA_W-1:0] eu_area;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign req_vtx       = '{x: in_chan.coord_x, y: in_chan.coord_y};

  // stored vertices sit at the top of the ring; the head reaches them in the last count steps
  assign span = (CNT_W+1)'(walk_r) + (CNT_W+1)'(count_r);

  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    drain_nxt     = drain_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    load_out      = 1'b0;
    cctrl         = '0;
    ectrl         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_chan.opcode)
            OP_CLEAR: begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
            end
            OP_APPEND: begin
              if (count_r < CNT_W'(MAX_VERTICES)) begin
                count_nxt      = count_r + CNT_W'(1);
                cctrl.shift_in = 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              ectrl.start = 1'b1;
              walk_nxt    = '0;
              state_nxt   = S_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        cctrl.rotate  = 1'b1;
        ectrl.edge_en = (count_r >= CNT_W'(MIN_POLY)) && (span >= (CNT_W+1)'(MAX_VERTICES));
        ectrl.first   = (span == (CNT_W+1)'(MAX_VERTICES));
        walk_nxt      = walk_r + IDX_W'(1);
        if (walk_r == IDX_W'(MAX_VERTICES - 1)) begin
          walk_nxt  = '0;
          drain_nxt = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == DRAIN_LAST) begin
          ectrl.finish = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= '0;
      drain_r     <= '0;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      drain_r     <= drain_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      inside_out_r  <= eu_inside;
      area_out_r    <= eu_area;
      vcount_out_r  <= VCOUNT_W'(count_r);
      dropped_out_r <= dropped_r;
    end
  end

  ppa_chain u_chain (
    .clk     (clk),
    .ctrl    (cctrl),
    .new_vtx (req_vtx),
    .head    (head),
    .tail    (tail)
  );

  ppa_edge_unit u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ectrl),
    .point   (req_vtx),
    .cur     (head),
    .prev    (tail),
    .in_poly (eu_inside),
    .area    (eu_area)
  );

  assign out_chan.valid        = out_valid_r;
  assign out_chan.inside_res   = inside_out_r;
  assign out_chan.twice_area   = area_out_r;
  assign out_chan.vertex_count = vcount_out_r;
  assign out_chan.dropped      = dropped_out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    dropped_r |-> (count_r == CNT_W'(MAX_VERTICES)))
    else $error("drop flag set while ring not full");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && walk_r == IDX_W'(MAX_VERTICES - 1)) |=> (state_r == S_DRAIN))
    else $error("walk did not end after one full rotation");

  a_idle_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (walk_r == '0))
    else $error("walk counter not rewound while taking requests");
`endif

endmodule
